@@ hw/rtl/lng_pkg.sv @@
// ----------------------------------------------------------------------------
// lng_pkg
// Shared types, codes and helpers of the lattice neighbor index generator.
// ----------------------------------------------------------------------------
package lng_pkg;

  typedef enum logic [1:0] {
    SHELL_NEAR  = 2'd0,
    SHELL_DIAG  = 2'd1,
    SHELL_DIST2 = 2'd2
  } shell_e;

  typedef enum logic [1:0] {
    CFG_SIZE_X     = 2'd0,
    CFG_SIZE_Y     = 2'd1,
    CFG_PERIODIC_X = 2'd2,
    CFG_PERIODIC_Y = 2'd3
  } cfg_reg_e;

  localparam int unsigned SizeW  = 9;
  localparam int unsigned IndexW = 16;
  localparam int unsigned NumCand = 4;

  // item header that travels through the pipe
  typedef struct packed {
    logic [1:0]        req_type;
    logic [IndexW-1:0] site_index;
    logic              bad;
  } tag_t;

  // per-candidate wrap result
  typedef struct packed {
    logic              ok;
    logic signed [2:0] kx;
    logic signed [2:0] ky;
    logic signed [1:0] cx;
    logic signed [1:0] cy;
  } cand_t;

  typedef struct packed {
    logic              valid_res;
    logic [IndexW-1:0] neighbor_index;
    logic signed [2:0] offset_x;
    logic signed [2:0] offset_y;
    logic signed [1:0] cross_x;
    logic signed [1:0] cross_y;
  } res_t;

  function automatic logic [SizeW-1:0] clamp_size(logic [SizeW-1:0] v,
                                                  logic [SizeW-1:0] max_v);
    logic [SizeW-1:0] r;
    r = v;
    if (v == '0) r = SizeW'(1);
    else if (v > max_v) r = max_v;
    return r;
  endfunction

  function automatic logic signed [2:0] shell_dx(logic [1:0] t, logic [1:0] k);
    logic signed [2:0] r;
    r = 3'sd0;
    case (t)
      SHELL_NEAR: begin
        case (k)
          2'd0: r = -3'sd1;
          2'd2: r = 3'sd1;
          default: r = 3'sd0;
        endcase
      end
      SHELL_DIAG: begin
        case (k)
          2'd0, 2'd3: r = -3'sd1;
          default: r = 3'sd1;
        endcase
      end
      SHELL_DIST2: begin
        case (k)
          2'd0: r = -3'sd2;
          2'd2: r = 3'sd2;
          default: r = 3'sd0;
        endcase
      end
      default: r = 3'sd0;
    endcase
    return r;
  endfunction

  function automatic logic signed [2:0] shell_dy(logic [1:0] t, logic [1:0] k);
    logic signed [2:0] r;
    r = 3'sd0;
    case (t)
      SHELL_NEAR: begin
        case (k)
          2'd1: r = -3'sd1;
          2'd3: r = 3'sd1;
          default: r = 3'sd0;
        endcase
      end
      SHELL_DIAG: begin
        case (k)
          2'd0, 2'd1: r = -3'sd1;
          default: r = 3'sd1;
        endcase
      end
      SHELL_DIST2: begin
        case (k)
          2'd1: r = -3'sd2;
          2'd3: r = 3'sd2;
          default: r = 3'sd0;
        endcase
      end
      default: r = 3'sd0;
    endcase
    return r;
  endfunction

  // k * v modulo 2^16 for k in -2..2
  function automatic logic [IndexW-1:0] scale16(logic signed [2:0] k,
                                                logic [IndexW-1:0] v);
    logic [IndexW-1:0] r;
    case (k)
      3'sd1:   r = v;
      3'sd2:   r = v << 1;
      -3'sd1:  r = -v;
      -3'sd2:  r = -(v << 1);
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

@@ hw/rtl/lng_if.sv @@
// ----------------------------------------------------------------------------
// lng_if
// Request and result channels of the lattice neighbor index generator.
// ----------------------------------------------------------------------------
interface lng_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [15:0] site_index;

  modport source (output valid, output req_type, output site_index, input ready);
  modport sink   (input valid, input req_type, input site_index, output ready);
endinterface

interface lng_res_if;
  logic              valid;
  logic              ready;
  logic              valid_res;
  logic [15:0]       neighbor_index;
  logic signed [2:0] offset_x;
  logic signed [2:0] offset_y;
  logic signed [1:0] cross_x;
  logic signed [1:0] cross_y;
  logic              last;

  modport source (output valid, output valid_res, output neighbor_index,
                  output offset_x, output offset_y, output cross_x,
                  output cross_y, output last, input ready);
  modport sink   (input valid, input valid_res, input neighbor_index,
                  input offset_x, input offset_y, input cross_x,
                  input cross_y, input last, output ready);
endinterface

@@ hw/rtl/lng_div_stage.sv @@
// ----------------------------------------------------------------------------
// lng_div_stage
// One restoring division step: decides one quotient bit of site / size_y.
// ----------------------------------------------------------------------------
module lng_div_stage #(
  parameter int unsigned XW  = 8,
  parameter int unsigned BIT = 0
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [8:0]         size_y_i,
  input  logic               valid_i,
  output logic               ready_o,
  input  lng_pkg::tag_t      tag_i,
  input  logic [15:0]        rem_i,
  input  logic [XW-1:0]      quo_i,
  output logic               valid_o,
  input  logic               ready_i,
  output lng_pkg::tag_t      tag_o,
  output logic [15:0]        rem_o,
  output logic [XW-1:0]      quo_o
);
  import lng_pkg::*;

  logic          valid_q;
  tag_t          tag_q;
  logic [15:0]   rem_q, rem_d;
  logic [XW-1:0] quo_q, quo_d;
  logic [16:0]   divisor;

  assign divisor = 17'(size_y_i) << BIT;

  always_comb begin
    rem_d = rem_i;
    quo_d = quo_i;
    if ({1'b0, rem_i} >= divisor) begin
      rem_d      = 16'({1'b0, rem_i} - divisor);
      quo_d[BIT] = 1'b1;
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      tag_q <= tag_i;
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign valid_o = valid_q;
  assign tag_o   = tag_q;
  assign rem_o   = rem_q;
  assign quo_o   = quo_q;

endmodule

@@ hw/rtl/lng_wrap.sv @@
// ----------------------------------------------------------------------------
// lng_wrap
// Applies the four shell offsets to (x, y), wraps or drops each axis and
// derives the boundary crossing signs of the nearest shell.
// ----------------------------------------------------------------------------
module lng_wrap #(
  parameter int unsigned XW = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [8:0]           size_x_i,
  input  logic [8:0]           size_y_i,
  input  logic                 periodic_x_i,
  input  logic                 periodic_y_i,
  input  logic                 valid_i,
  output logic                 ready_o,
  input  lng_pkg::tag_t        tag_i,
  input  logic [XW-1:0]        x_i,
  input  logic [XW-1:0]        y_i,
  output logic                 valid_o,
  input  logic                 ready_i,
  output lng_pkg::tag_t        tag_o,
  output lng_pkg::cand_t [3:0] cand_o
);
  import lng_pkg::*;

  logic        valid_q;
  tag_t        tag_q;
  cand_t [3:0] cand_q, cand_d;

  // returns {ok, wrap count, wrapped coordinate}
  function automatic logic [XW+3:0] wrap_axis(logic [XW-1:0] c, logic signed [2:0] d,
                                              logic [8:0] s, logic per);
    logic signed [10:0] t, ss, lo1, hi1, n;
    logic               ok;
    logic signed [2:0]  k;
    t   = $signed({{(11-XW){1'b0}}, c}) + $signed({{8{d[2]}}, d});
    ss  = $signed({2'b00, s});
    lo1 = t + ss;
    hi1 = t - ss;
    ok  = 1'b1;
    k   = 3'sd0;
    n   = t;
    if (per) begin
      if (t < 11'sd0) begin
        // size one needs a second wrap for a step of two
        if (lo1 < 11'sd0) begin
          n = lo1 + ss;
          k = 3'sd2;
        end else begin
          n = lo1;
          k = 3'sd1;
        end
      end else if (t >= ss) begin
        if (hi1 >= ss) begin
          n = hi1 - ss;
          k = -3'sd2;
        end else begin
          n = hi1;
          k = -3'sd1;
        end
      end
    end else begin
      ok = (t >= 11'sd0) && (t < ss);
    end
    return {ok, k, n[XW-1:0]};
  endfunction

  function automatic logic signed [1:0] far_sign(logic [XW-1:0] a, logic [XW-1:0] b);
    logic signed [10:0] d;
    logic signed [1:0]  r;
    d = $signed({{(11-XW){1'b0}}, a}) - $signed({{(11-XW){1'b0}}, b});
    r = 2'sd0;
    if (d > 11'sd1) r = 2'sd1;
    else if (d < -11'sd1) r = -2'sd1;
    return r;
  endfunction

  always_comb begin
    logic [XW+3:0] ax, ay;
    for (int k = 0; k < 4; k++) begin
      ax = wrap_axis(x_i, shell_dx(tag_i.req_type, 2'(k)), size_x_i, periodic_x_i);
      ay = wrap_axis(y_i, shell_dy(tag_i.req_type, 2'(k)), size_y_i, periodic_y_i);
      cand_d[k].ok = ax[XW+3] && ay[XW+3];
      cand_d[k].kx = ax[XW+2:XW];
      cand_d[k].ky = ay[XW+2:XW];
      cand_d[k].cx = 2'sd0;
      cand_d[k].cy = 2'sd0;
      if (tag_i.req_type == SHELL_NEAR) begin
        cand_d[k].cx = far_sign(x_i, ax[XW-1:0]);
        cand_d[k].cy = far_sign(y_i, ay[XW-1:0]);
      end
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      tag_q  <= tag_i;
      cand_q <= cand_d;
    end
  end

  assign valid_o = valid_q;
  assign tag_o   = tag_q;
  assign cand_o  = cand_q;

endmodule

@@ hw/rtl/lng_index.sv @@
// ----------------------------------------------------------------------------
// lng_index
// Recomposes the neighbor index of each candidate from the site index and
// builds the result records and the survivor mask.
// ----------------------------------------------------------------------------
module lng_index (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [15:0]          size_y_i,
  input  logic [15:0]          area_i,
  input  logic                 valid_i,
  output logic                 ready_o,
  input  lng_pkg::tag_t        tag_i,
  input  lng_pkg::cand_t [3:0] cand_i,
  output logic                 valid_o,
  input  logic                 ready_i,
  output logic [3:0]           mask_o,
  output lng_pkg::res_t [3:0]  res_o
);
  import lng_pkg::*;

  logic       valid_q;
  logic [3:0] mask_q, mask_d;
  res_t [3:0] res_q, res_d;

  // index = site + (nx - x) * size_y + (ny - y), all modulo 2^16;
  // (nx - x) * size_y = dx * size_y + kx * size_x * size_y
  always_comb begin
    logic signed [2:0] dx, dy;
    for (int k = 0; k < 4; k++) begin
      dx = shell_dx(tag_i.req_type, 2'(k));
      dy = shell_dy(tag_i.req_type, 2'(k));
      mask_d[k]                = cand_i[k].ok;
      res_d[k].valid_res       = 1'b1;
      res_d[k].neighbor_index  = tag_i.site_index + scale16(dx, size_y_i)
                               + scale16(cand_i[k].kx, area_i)
                               + scale16(cand_i[k].ky, size_y_i)
                               + {{13{dy[2]}}, dy};
      res_d[k].offset_x        = dx;
      res_d[k].offset_y        = dy;
      res_d[k].cross_x         = cand_i[k].cx;
      res_d[k].cross_y         = cand_i[k].cy;
    end
    // no survivor or bad request: a single all-zero record
    if (tag_i.bad || (mask_d == 4'b0000)) begin
      mask_d   = 4'b0001;
      res_d[0] = '0;
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      mask_q <= mask_d;
      res_q  <= res_d;
    end
  end

  assign valid_o = valid_q;
  assign mask_o  = mask_q;
  assign res_o   = res_q;

endmodule

@@ hw/rtl/lng_serial.sv @@
// ----------------------------------------------------------------------------
// lng_serial
// Holds one item's records and hands out the surviving ones in order, one
// result transaction per cycle while res_o.ready is high; marks the final one.
// ----------------------------------------------------------------------------
module lng_serial (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  output logic                ready_o,
  input  logic [3:0]          mask_i,
  input  lng_pkg::res_t [3:0] res_i,
  lng_res_if.source           res_o
);
  import lng_pkg::*;

  logic       valid_q, valid_d;
  logic [3:0] mask_q, mask_d;
  res_t [3:0] rec_q;
  logic [1:0] sel;
  logic [3:0] sel_hot;
  logic       last;
  logic       take;

  // lowest pending record
  always_comb begin
    sel = 2'd0;
    for (int k = 3; k >= 0; k--) begin
      if (mask_q[k]) sel = 2'(k);
    end
  end

  assign sel_hot = 4'b0001 << sel;
  assign last    = (mask_q & ~sel_hot) == 4'b0000;
  assign take    = valid_q && res_o.ready;
  assign ready_o = !valid_q || (take && last);

  always_comb begin
    valid_d = valid_q;
    mask_d  = mask_q;
    if (ready_o) begin
      valid_d = valid_i;
      mask_d  = mask_i;
    end else if (take) begin
      mask_d = mask_q & ~sel_hot;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      mask_q  <= 4'b0000;
    end else begin
      valid_q <= valid_d;
      mask_q  <= mask_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      rec_q <= res_i;
    end
  end

  assign res_o.valid          = valid_q;
  assign res_o.valid_res      = rec_q[sel].valid_res;
  assign res_o.neighbor_index = rec_q[sel].neighbor_index;
  assign res_o.offset_x       = rec_q[sel].offset_x;
  assign res_o.offset_y       = rec_q[sel].offset_y;
  assign res_o.cross_x        = rec_q[sel].cross_x;
  assign res_o.cross_y        = rec_q[sel].cross_y;
  assign res_o.last           = last;

endmodule

@@ hw/rtl/lattice_neighbor_index_gen_top.sv @@
// ----------------------------------------------------------------------------
// lattice_neighbor_index_gen_top
// Pipeline: a request passes one range-check stage, one division stage per
// quotient bit, a wrap stage, an index stage and an output hold stage.
// Throughput: one request per cycle while the output stage accepts; a
// request with n surviving neighbors (1 to 4) holds the output stage until
// its last result is taken, one result per cycle while res_o.ready is high.
// Reset clears all valid bits; sizes reset to 1 and both axes to periodic.
// ----------------------------------------------------------------------------
module lattice_neighbor_index_gen_top #(
  parameter int unsigned MAX_SIDE = 256
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_idx_i,
  input  logic [8:0] cfg_data_i,
  lng_req_if.sink    req_i,
  lng_res_if.source  res_o
);
  import lng_pkg::*;

  localparam int unsigned XW = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;

  logic [8:0]  size_x_q, size_y_q;
  logic        periodic_x_q, periodic_y_q;
  logic [8:0]  sx, sy;
  logic [17:0] area;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_x_q     <= 9'd1;
      size_y_q     <= 9'd1;
      periodic_x_q <= 1'b1;
      periodic_y_q <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SIZE_X:     size_x_q     <= cfg_data_i;
        CFG_SIZE_Y:     size_y_q     <= cfg_data_i;
        CFG_PERIODIC_X: periodic_x_q <= cfg_data_i[0];
        CFG_PERIODIC_Y: periodic_y_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign sx   = clamp_size(size_x_q, 9'(MAX_SIDE));
  assign sy   = clamp_size(size_y_q, 9'(MAX_SIDE));
  assign area = sx * sy;

  // range check stage
  logic a_valid_q;
  tag_t a_tag_q, a_tag_d;

  logic                div_valid [XW+1];
  logic                div_ready [XW+1];
  tag_t                div_tag   [XW+1];
  logic [15:0]         div_rem   [XW+1];
  logic [XW-1:0]       div_quo   [XW+1];

  always_comb begin
    a_tag_d.req_type   = req_i.req_type;
    a_tag_d.site_index = req_i.site_index;
    a_tag_d.bad        = (req_i.req_type > SHELL_DIST2)
                      || ({2'b00, req_i.site_index} >= area);
  end

  assign req_i.ready = !a_valid_q || div_ready[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (req_i.ready) begin
      a_valid_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.ready && req_i.valid) begin
      a_tag_q <= a_tag_d;
    end
  end

  assign div_valid[0] = a_valid_q;
  assign div_tag[0]   = a_tag_q;
  assign div_rem[0]   = a_tag_q.site_index;
  assign div_quo[0]   = '0;

  for (genvar s = 0; s < XW; s++) begin : g_div
    lng_div_stage #(
      .XW  (XW),
      .BIT (XW - 1 - s)
    ) u_div (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .size_y_i (sy),
      .valid_i  (div_valid[s]),
      .ready_o  (div_ready[s]),
      .tag_i    (div_tag[s]),
      .rem_i    (div_rem[s]),
      .quo_i    (div_quo[s]),
      .valid_o  (div_valid[s+1]),
      .ready_i  (div_ready[s+1]),
      .tag_o    (div_tag[s+1]),
      .rem_o    (div_rem[s+1]),
      .quo_o    (div_quo[s+1])
    );
  end

  logic        w_valid, w_ready;
  tag_t        w_tag;
  cand_t [3:0] w_cand;

  lng_wrap #(
    .XW (XW)
  ) u_wrap (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .size_x_i     (sx),
    .size_y_i     (sy),
    .periodic_x_i (periodic_x_q),
    .periodic_y_i (periodic_y_q),
    .valid_i      (div_valid[XW]),
    .ready_o      (div_ready[XW]),
    .tag_i        (div_tag[XW]),
    .x_i          (div_quo[XW]),
    .y_i          (div_rem[XW][XW-1:0]),
    .valid_o      (w_valid),
    .ready_i      (w_ready),
    .tag_o        (w_tag),
    .cand_o       (w_cand)
  );

  logic       x_valid, x_ready;
  logic [3:0] x_mask;
  res_t [3:0] x_res;

  lng_index u_index (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .size_y_i (16'(sy)),
    .area_i   (area[15:0]),
    .valid_i  (w_valid),
    .ready_o  (w_ready),
    .tag_i    (w_tag),
    .cand_i   (w_cand),
    .valid_o  (x_valid),
    .ready_i  (x_ready),
    .mask_o   (x_mask),
    .res_o    (x_res)
  );

  lng_serial u_serial (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (x_valid),
    .ready_o (x_ready),
    .mask_i  (x_mask),
    .res_i   (x_res),
    .res_o   (res_o)
  );

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the lattice neighbor index generator against an in-bench predictor.
// Directed items probe reset defaults, size clamping and boundary handling;
// random phases then sweep lattice shapes, boundary modes and shells while
// both channels idle at random, but for one calm phase.
// ----------------------------------------------------------------------------
module testbench;
  import lng_pkg::*;

  localparam int MaxSide    = 256;
  localparam int LatCycles  = $clog2(MaxSide) + 4;
  localparam int CycleLimit = 200000;
  localparam int PhaseItems = 44;
  localparam logic [1:0] SHELL_UNUSED = 2'd3;

  typedef struct packed {
    logic              valid_res;
    logic [15:0]       idx;
    logic signed [2:0] ox;
    logic signed [2:0] oy;
    logic signed [1:0] cx;
    logic signed [1:0] cy;
    logic              last;
  } nbr_t;

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  cfg_reg_e   cfg_idx;
  logic [8:0] cfg_data;
  logic       calm;
  int         mismatches;
  int         cycles;

  // lattice registers as the block should hold them
  logic [8:0] size_x_q;
  logic [8:0] size_y_q;
  logic       per_x_q;
  logic       per_y_q;

  nbr_t expected_nbrs[$];

  lng_req_if req_ch();
  lng_res_if res_ch();

  lattice_neighbor_index_gen_top #(
    .MAX_SIDE(MaxSide)
  ) u_dut (
    .clk_i     (clk),
    .rst_ni    (rst_n),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data),
    .req_i     (req_ch),
    .res_o     (res_ch)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic int eff_size(logic [8:0] v);
    if (v == 9'd0) return 1;
    if (int'(v) > MaxSide) return MaxSide;
    return int'(v);
  endfunction

  function automatic logic signed [1:0] far_sign(int d);
    if (d > 1) return 2'sd1;
    if (d < -1) return -2'sd1;
    return 2'sd0;
  endfunction

  function automatic void shell_step(input logic [1:0] shell, input int k,
                                     output int dx, output int dy);
    case (shell)
      SHELL_NEAR: begin
        dx = (k == 0) ? -1 : (k == 2) ? 1 : 0;
        dy = (k == 1) ? -1 : (k == 3) ? 1 : 0;
      end
      SHELL_DIAG: begin
        dx = (k == 0 || k == 3) ? -1 : 1;
        dy = (k < 2) ? -1 : 1;
      end
      default: begin
        dx = (k == 0) ? -2 : (k == 2) ? 2 : 0;
        dy = (k == 1) ? -2 : (k == 3) ? 2 : 0;
      end
    endcase
  endfunction

  // queue the neighbors that one request should produce
  function automatic void list_neighbors(logic [1:0] shell, logic [15:0] site);
    int   sx, sy, x, y, nx, ny, dx, dy;
    nbr_t r;
    nbr_t found[$];
    sx = eff_size(size_x_q);
    sy = eff_size(size_y_q);
    r  = '0;
    if (shell == SHELL_UNUSED || int'(site) >= sx * sy) begin
      r.last = 1'b1;
      expected_nbrs = {expected_nbrs, r};
      return;
    end
    x = int'(site) / sy;
    y = int'(site) % sy;
    for (int k = 0; k < 4; k++) begin
      shell_step(shell, k, dx, dy);
      nx = x + dx;
      ny = y + dy;
      if (per_x_q) nx = (nx + 2 * sx) % sx;
      else if (nx < 0 || nx >= sx) continue;
      if (per_y_q) ny = (ny + 2 * sy) % sy;
      else if (ny < 0 || ny >= sy) continue;
      r = '0;
      r.valid_res = 1'b1;
      r.idx = 16'(nx * sy + ny);
      r.ox  = 3'(dx);
      r.oy  = 3'(dy);
      if (shell == SHELL_NEAR) begin
        r.cx = far_sign(x - nx);
        r.cy = far_sign(y - ny);
      end
      found = {found, r};
    end
    if (found.size() == 0) begin
      r = '0;
      found = {found, r};
    end
    foreach (found[i]) begin
      r = found[i];
      r.last = (i == found.size() - 1);
      expected_nbrs = {expected_nbrs, r};
    end
  endfunction

  function automatic logic idle_now();
    return !calm && ($urandom_range(99) < 16);
  endfunction

  // result side: random back-pressure
  always @(negedge clk) begin
    res_ch.ready <= !idle_now();
  end

  // result checker
  always @(posedge clk) begin
    nbr_t got, want;
    if (rst_n && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
      got.valid_res = res_ch.valid_res;
      got.idx       = res_ch.neighbor_index;
      got.ox        = res_ch.offset_x;
      got.oy        = res_ch.offset_y;
      got.cx        = res_ch.cross_x;
      got.cy        = res_ch.cross_y;
      got.last      = res_ch.last;
      if (expected_nbrs.size() == 0) begin
        mismatches = mismatches + 1;
        if (mismatches <= 10)
          $display("%0t: result transaction with nothing expected", $realtime);
      end else begin
        want = expected_nbrs.pop_front();
        if (got !== want) begin
          mismatches = mismatches + 1;
          if (mismatches <= 10)
            $display({"%0t: mismatch exp v=%0d idx=%0d ox=%0d oy=%0d cx=%0d cy=%0d ",
                      "last=%0d got v=%0d idx=%0d ox=%0d oy=%0d cx=%0d cy=%0d last=%0d"},
                     $realtime, want.valid_res, want.idx, want.ox, want.oy, want.cx,
                     want.cy, want.last, got.valid_res, got.idx, got.ox, got.oy,
                     got.cx, got.cy, got.last);
        end
      end
    end
  end

  task automatic send_site(input logic [1:0] shell, input logic [15:0] site);
    @(negedge clk);
    while (idle_now()) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    req_ch.valid      <= 1'b1;
    req_ch.req_type   <= shell;
    req_ch.site_index <= site;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    list_neighbors(shell, site);
  endtask

  // stop requests and wait until every neighbor has come back
  task automatic settle();
    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (expected_nbrs.size() != 0) @(posedge clk);
    repeat (2 * LatCycles) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [8:0] val);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    case (idx)
      CFG_SIZE_X:     size_x_q = val;
      CFG_SIZE_Y:     size_y_q = val;
      CFG_PERIODIC_X: per_x_q  = val[0];
      default:        per_y_q  = val[0];
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_lattice(input logic [8:0] sx, input logic [8:0] sy,
                             input logic px, input logic py);
    settle();
    write_reg(CFG_SIZE_X, sx);
    write_reg(CFG_SIZE_Y, sy);
    // upper data bits of the mode registers are don't-care
    write_reg(CFG_PERIODIC_X, {8'($urandom), px});
    write_reg(CFG_PERIODIC_Y, {8'($urandom), py});
  endtask

  task automatic send_random_item();
    int          sx, sy, span, pick;
    logic [1:0]  shell;
    logic [15:0] site;
    sx   = eff_size(size_x_q);
    sy   = eff_size(size_y_q);
    span = sx * sy;
    pick = $urandom_range(99);
    shell = (pick < 7) ? SHELL_UNUSED : 2'($urandom_range(2));
    pick = $urandom_range(99);
    if (pick < 70) begin
      site = 16'($urandom_range(span - 1));
    end else if (pick < 85) begin
      // corners hit the boundary on both axes
      site = 16'(($urandom_range(1) ? sx - 1 : 0) * sy + ($urandom_range(1) ? sy - 1 : 0));
    end else begin
      site = 16'($urandom);
    end
    send_site(shell, site);
  endtask

  task automatic test_reset_state();
    send_site(SHELL_NEAR, 16'd0);
    send_site(SHELL_DIAG, 16'd0);
    send_site(SHELL_DIST2, 16'd0);
    send_site(SHELL_NEAR, 16'd1);
    send_site(SHELL_UNUSED, 16'd0);
  endtask

  task automatic test_size_clamp();
    set_lattice(9'd0, 9'd511, 1'b0, 1'b0);
    send_site(SHELL_NEAR, 16'd0);
    send_site(SHELL_NEAR, 16'd255);
    send_site(SHELL_DIAG, 16'd256);
    send_site(SHELL_DIST2, 16'hFFFF);
  endtask

  task automatic test_boundaries();
    set_lattice(9'd256, 9'd256, 1'b1, 1'b1);
    send_site(SHELL_NEAR, 16'd0);
    send_site(SHELL_NEAR, 16'hFFFF);
    send_site(SHELL_DIAG, 16'hFFFF);
    send_site(SHELL_DIST2, 16'd0);
    send_site(SHELL_DIST2, 16'h8080);
    set_lattice(9'd256, 9'd256, 1'b0, 1'b0);
    send_site(SHELL_NEAR, 16'd0);
    send_site(SHELL_DIAG, 16'hFFFF);
    send_site(SHELL_DIST2, 16'h0101);
    // single open site has no neighbor at all
    set_lattice(9'd1, 9'd1, 1'b0, 1'b0);
    send_site(SHELL_NEAR, 16'd0);
    // tiny periodic lattice folds distance-two neighbors onto the site itself
    set_lattice(9'd2, 9'd2, 1'b1, 1'b1);
    send_site(SHELL_DIST2, 16'd3);
    send_site(SHELL_NEAR, 16'd0);
    send_site(SHELL_UNUSED, 16'd2);
  endtask

  task automatic test_random_lattices();
    logic [8:0] sx, sy;
    logic       px, py;
    for (int p = 0; p < 8; p++) begin
      px = 1'($urandom);
      py = 1'($urandom);
      sx = 9'($urandom_range(1, 16));
      sy = 9'($urandom_range(1, 16));
      case (p)
        0: begin sx = 9'd256; sy = 9'd256; end
        1: begin sx = 9'd0; sy = 9'($urandom_range(1, 256)); end
        2: begin sx = 9'($urandom_range(257, 511)); sy = 9'($urandom_range(1, 8)); end
        3: begin sx = 9'($urandom_range(1, 12)); sy = 9'($urandom_range(1, 12)); end
        4: begin sx = 9'($urandom_range(1, 256)); sy = 9'($urandom_range(1, 4)); end
        default: ;
      endcase
      set_lattice(sx, sy, px, py);
      calm = (p == 3);
      for (int i = 0; i < PhaseItems; i++) send_random_item();
      calm = 1'b0;
    end
  endtask

  initial begin
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_idx           = CFG_SIZE_X;
    cfg_data          = '0;
    calm              = 1'b0;
    mismatches        = 0;
    cycles            = 0;
    req_ch.valid      = 1'b0;
    req_ch.req_type   = SHELL_NEAR;
    req_ch.site_index = '0;
    res_ch.ready      = 1'b0;
    size_x_q          = 9'd1;
    size_y_q          = 9'd1;
    per_x_q           = 1'b1;
    per_y_q           = 1'b1;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_reset_state();
    test_size_clamp();
    test_boundaries();
    test_random_lattices();

    settle();
    if (mismatches == 0 && expected_nbrs.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
